### src/gkde_pkg.sv
// gkde_pkg: shared types and constants for the gaussian kernel distance block
// holds the command/status structs, fixed widths and the 2^-(2^-(j+1)) factor table
// no dependencies
package gkde_pkg;

   // fixed field widths
   localparam int SUM_W   = 48;
   localparam int GAMMA_W = 24;
   localparam int KERN_W  = 17;
   localparam int PROD_W  = 72;
   localparam int MUL_W   = 32;
   localparam int T_W     = 22;
   localparam int FACT_W  = 31;

   // exponent clamp at 32.0 in Q.16
   localparam logic [T_W-1:0]    T_CAP     = 22'h20_0000;
   // log2(e) in Q1.30
   localparam logic [FACT_W-1:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [FACT_W-1:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [63:0]       HALF_Q30  = 64'h2000_0000;

   // commands from the controller, at most one active per cycle
   typedef struct packed {
      logic accept;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic clamp;
      logic mul_log;
      logic split;
      logic emul;
      logic ernd;
      logic load_out;
   } gkde_cmd_type;

   // status back to the controller
   typedef struct packed {
      logic exp_last;
      logic out_full;
   } gkde_sts_type;

   // factors 2^-(2^-(idx+1)) in Q1.30
   function automatic logic [FACT_W-1:0] pow2_neg_factor(input logic [3:0] idx);
      logic [FACT_W-1:0] f;
      f = ONE_Q30;
      case (idx)
         4'd0:  f = 31'd759250125;
         4'd1:  f = 31'd902905651;
         4'd2:  f = 31'd984625594;
         4'd3:  f = 31'd1028218693;
         4'd4:  f = 31'd1050733751;
         4'd5:  f = 31'd1062175491;
         4'd6:  f = 31'd1067942999;
         4'd7:  f = 31'd1070838486;
         4'd8:  f = 31'd1072289173;
         4'd9:  f = 31'd1073015252;
         4'd10: f = 31'd1073378477;
         4'd11: f = 31'd1073560135;
         4'd12: f = 31'd1073650976;
         4'd13: f = 31'd1073696399;
         4'd14: f = 31'd1073719111;
         4'd15: f = 31'd1073730468;
         default: f = ONE_Q30;
      endcase
      return f;
   endfunction

endpackage

### src/gkde_ctrl.sv
// gkde_ctrl: sequencer for the kernel block
// steps the datapath through accumulate, exponent scaling and the exponential
// depends on gkde_pkg
module gkde_ctrl import gkde_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last_component,
   output logic         req_stall,
   output gkde_cmd_type cmd,
   input  gkde_sts_type sts
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DRAIN = 4'd1;
   localparam logic [3:0] S_MLO   = 4'd2;
   localparam logic [3:0] S_MHI   = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_CLAMP = 4'd5;
   localparam logic [3:0] S_LOG   = 4'd6;
   localparam logic [3:0] S_SPLIT = 4'd7;
   localparam logic [3:0] S_EMUL  = 4'd8;
   localparam logic [3:0] S_ERND  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   // words are taken only while accumulating
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            if (accept && req_last_component) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_MLO;
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_LOG;
         end
         S_LOG: begin
            cmd.mul_log = 1'b1;
            state_in    = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_EMUL;
         end
         S_EMUL: begin
            cmd.emul = 1'b1;
            state_in = S_ERND;
         end
         S_ERND: begin
            cmd.ernd = 1'b1;
            state_in = sts.exp_last ? S_OUT : S_EMUL;
         end
         S_OUT: begin
            cmd.load_out = !sts.out_full;
            if (!sts.out_full) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/gkde_dpath.sv
// gkde_dpath: datapath of the kernel block
// square-accumulate front end, shared 32x32 multiplier, exponential and result register
// depends on gkde_pkg
module gkde_dpath import gkde_pkg::*; #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gkde_cmd_type                     cmd,
   output gkde_sts_type                     sts,
   input  logic signed [COMPONENT_BITS-1:0] req_x_component,
   input  logic signed [COMPONENT_BITS-1:0] req_y_component,
   input  logic                             csr_wr_en,
   input  logic        [GAMMA_W-1:0]        csr_wr_data,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic        [KERN_W-1:0]         rsp_kernel_value,
   output logic                             rsp_distance_saturated
);

   localparam int DIFF_W     = COMPONENT_BITS + 1;
   localparam int SQ_W       = 2 * COMPONENT_BITS;
   localparam int DIST_SHIFT = 2 * (COMPONENT_BITS - 4);

   // front end
   logic signed [DIFF_W-1:0]         diff;
   logic        [DIFF_W-1:0]         diff_neg;
   logic        [COMPONENT_BITS-1:0] mag;
   logic        [SQ_W-1:0]           sq_in;
   logic        [SQ_W-1:0]           sq_ff;
   logic                             sqv_ff;
   logic        [SUM_W:0]            sum_ext;
   logic        [SUM_W-1:0]          acc_ff;
   logic                             sat_ff;

   // back end
   logic [GAMMA_W-1:0] gamma_ff;
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [63:0]        mul_prod;
   logic [63:0]        mul_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_shr;
   logic [T_W-1:0]     t_ff;
   logic [5:0]         n_ff;
   logic [15:0]        f16_ff;
   logic [FACT_W-1:0]  eacc_ff;
   logic [3:0]         j_ff;
   logic [63:0]        rnd;
   logic               res_sat_ff;
   logic [5:0]         sh;
   logic [31:0]        kern_rnd;
   logic [31:0]        kern_shr;
   logic [KERN_W-1:0]  kern_in;

   // output register
   logic               rsp_valid_ff;
   logic [KERN_W-1:0]  kern_ff;
   logic               osat_ff;

   // difference magnitude and its square
   assign diff     = DIFF_W'(req_x_component) - DIFF_W'(req_y_component);
   assign diff_neg = -diff;
   assign mag      = diff[DIFF_W-1] ? diff_neg[COMPONENT_BITS-1:0]
                                    : diff[COMPONENT_BITS-1:0];
   assign sq_in    = SQ_W'(mag) * SQ_W'(mag);

   // saturating accumulate, carry out means overflow
   assign sum_ext = {1'b0, acc_ff} + (SUM_W + 1)'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         sqv_ff <= cmd.accept;
         if (cmd.mul_hi) begin
            acc_ff <= '0;
            sat_ff <= 1'b0;
         end else if (sqv_ff) begin
            if (sum_ext[SUM_W]) begin
               acc_ff <= '1;
               sat_ff <= 1'b1;
            end else begin
               acc_ff <= sum_ext[SUM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) sq_ff <= sq_in;
   end

   // gamma register
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_W'(65536);
      end else if (csr_wr_en) begin
         gamma_ff <= csr_wr_data;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = {{(MUL_W-FACT_W){1'b0}}, eacc_ff};
      mul_b = {{(MUL_W-FACT_W){1'b0}},
               f16_ff[4'd15 - j_ff] ? pow2_neg_factor(j_ff) : ONE_Q30};
      if (cmd.mul_lo) begin
         mul_a = MUL_W'(gamma_ff);
         mul_b = MUL_W'(acc_ff[23:0]);
      end else if (cmd.mul_hi) begin
         mul_a = MUL_W'(gamma_ff);
         mul_b = MUL_W'(acc_ff[47:24]);
      end else if (cmd.mul_log) begin
         mul_a = MUL_W'(t_ff);
         mul_b = MUL_W'(LOG2E_Q30);
      end
   end

   assign mul_prod = 64'(mul_a) * 64'(mul_b);
   assign prod_shr = prod_ff >> DIST_SHIFT;
   assign rnd      = mul_ff + HALF_Q30;

   // exponent scaling and base-2 reduction
   always_ff @(posedge clock) begin
      if (cmd.mul_lo || cmd.mul_hi || cmd.mul_log || cmd.emul) mul_ff <= mul_prod;
      if (cmd.mul_hi) begin
         prod_ff    <= PROD_W'(mul_ff[47:0]);
         res_sat_ff <= sat_ff;
      end
      if (cmd.sum) prod_ff <= prod_ff + {mul_ff[47:0], 24'd0};
      if (cmd.clamp) t_ff <= (prod_shr > PROD_W'(T_CAP)) ? T_CAP : prod_shr[T_W-1:0];
      if (cmd.split) begin
         n_ff    <= mul_ff[51:46];
         f16_ff  <= mul_ff[45:30];
         eacc_ff <= ONE_Q30;
         j_ff    <= 4'd0;
      end
      if (cmd.ernd) begin
         eacc_ff <= rnd[60:30];
         j_ff    <= j_ff + 4'd1;
      end
   end

   assign sts.exp_last = (j_ff == 4'd15);
   assign sts.out_full = rsp_valid_ff;

   // final shift by 14 + integer part, rounded half up
   assign sh       = n_ff + 6'd14;
   assign kern_rnd = {1'b0, eacc_ff} + (32'd1 << (sh - 6'd1));
   assign kern_shr = kern_rnd >> sh;
   assign kern_in  = (sh > 6'd40) ? '0 : kern_shr[KERN_W-1:0];

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kern_ff <= kern_in;
         osat_ff <= res_sat_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kernel_value       = kern_ff;
   assign rsp_distance_saturated = osat_ff;

endmodule

### src/gaussian_kernel_distance_exp_top.sv
// gaussian_kernel_distance_exp_top: gaussian kernel exp(-gamma*||x-y||^2) per vector pair
// non-last words are taken one per cycle while the sequencer is idle; a last word stalls input
// while the sequencer runs 6 scaling steps (low/high gamma products, sum, clamp, log2(e) product,
// split), then 16 factor steps of a multiply and a round each; the next word is taken in the
// cycle after the result is loaded; synchronous active-high reset clears the accumulator, flags,
// sequencer and result valid flag, and sets gamma to 1.0; depends on gkde_pkg, gkde_ctrl, gkde_dpath
module gaussian_kernel_distance_exp_top import gkde_pkg::*; #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COMPONENT_BITS-1:0] req_x_component,
   input  logic signed [COMPONENT_BITS-1:0] req_y_component,
   input  logic                             req_last_component,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic        [KERN_W-1:0]         rsp_kernel_value,
   output logic                             rsp_distance_saturated,
   input  logic                             csr_wr_en,
   input  logic        [GAMMA_W-1:0]        csr_wr_data
);

   gkde_cmd_type cmd;
   gkde_sts_type sts;

   // sequencer
   gkde_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_last_component (req_last_component),
      .req_stall          (req_stall),
      .cmd                (cmd),
      .sts                (sts)
   );

   // datapath
   gkde_dpath #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_x_component        (req_x_component),
      .req_y_component        (req_y_component),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_kernel_value       (rsp_kernel_value),
      .rsp_distance_saturated (rsp_distance_saturated)
   );

   // checks
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_component |=> req_stall)
      else $error("input not stalled after a last word");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid)
      else $error("result loaded over a pending word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result valid without a load");

endmodule
